// ===== src/xdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// xdsd_pkg
// Shared constants, types and helpers for the XOR double stream decoder.
// ----------------------------------------------------------------------------
package xdsd_pkg;

   localparam int TABLE_DEPTH  = 32;
   localparam int TABLE_ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [63:0] END_MARKER_RESET = 64'h7FF8_0000_0000_0000;

   // parse phases
   localparam logic [3:0] PH_FLAG   = 4'd0;
   localparam logic [3:0] PH_LCOUNT = 4'd1;
   localparam logic [3:0] PH_LENTRY = 4'd2;
   localparam logic [3:0] PH_TCOUNT = 4'd3;
   localparam logic [3:0] PH_TENTRY = 4'd4;
   localparam logic [3:0] PH_FTZ    = 4'd5;
   localparam logic [3:0] PH_FBODY  = 4'd6;
   localparam logic [3:0] PH_CTRL   = 4'd7;
   localparam logic [3:0] PH_CTRL2  = 4'd8;
   localparam logic [3:0] PH_IDX    = 4'd9;
   localparam logic [3:0] PH_CENTER = 4'd10;

   // datapath operations
   localparam logic [3:0] OP_NONE        = 4'd0;
   localparam logic [3:0] OP_LCOUNT      = 4'd1;
   localparam logic [3:0] OP_TCOUNT      = 4'd2;
   localparam logic [3:0] OP_LENTRY      = 4'd3;
   localparam logic [3:0] OP_TENTRY      = 4'd4;
   localparam logic [3:0] OP_FTZ         = 4'd5;
   localparam logic [3:0] OP_EMIT_ZERO   = 4'd6;
   localparam logic [3:0] OP_EMIT_BODY   = 4'd7;
   localparam logic [3:0] OP_EMIT_PREV   = 4'd8;
   localparam logic [3:0] OP_EMIT_CENTER = 4'd9;
   localparam logic [3:0] OP_LOOKUP      = 4'd10;
   localparam logic [3:0] OP_HELD        = 4'd11;
   localparam logic [3:0] OP_FLUSH       = 4'd12;

   typedef struct packed {
      logic       shift;
      logic       shift_bit;
      logic       clear;
      logic       restart;
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic       pend_valid;
      logic       out_free;
      logic [6:0] gather_low;
      logic       fill_more;
      logic       awaiting;
      logic [6:0] center_width;
      logic [3:0] index_width;
   } status_type;

   // ceil(log2(n)) capped at 5, for n of 1..32
   function automatic logic [2:0] index_width(input logic [5:0] n);
      logic [2:0] w;
      w = 3'd0;
      for (int i = 0; i < 5; i++) begin
         if ((6'd1 << w) < n) begin
            w = w + 3'd1;
         end
      end
      return w;
   endfunction

endpackage

// ===== src/xor_double_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// xor_double_stream_decoder_top
// Decodes an XOR-coded stream of 64-bit double words, one byte per request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_command, req_stream_byte
//  rsp      out        rsp_valid/stall    rsp_value_bits, rsp_end_of_stream,
//                                         rsp_last_of_run
//  csr      in         csr_wr_en          csr_wr_data (end marker)
//
// A data request is accepted in idle; the sequencer then walks the byte bit
// by bit, finishes each field that closes (a table lookup adds a lookup and
// a center step) and ends the byte in an end state; result stalls hold it and
// no new request is taken until it is idle again. A restart request is
// handled in the accept state.
// Reset is synchronous, active high; table contents are not cleared.
// The newest word of a byte waits in a pending slot so the last one can be
// flagged; the sequencer holds while the result register is stalled.
module xor_double_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value_bits,
   output logic        rsp_end_of_stream,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);
   import xdsd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walk bits, step phases
   xdsd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_stream_byte (req_stream_byte),
      .status          (status),
      .cmd             (cmd)
   );

   // datapath: gather, tables, word rebuild, result register
   xdsd_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_bits    (rsp_value_bits),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== src/xdsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// xdsd_ctrl
// Bit sequencer: walks the request byte and steps the parse phases.
// ----------------------------------------------------------------------------
module xdsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [7:0]          req_stream_byte,
   input  xdsd_pkg::status_type status,
   output xdsd_pkg::cmd_type   cmd
);
   import xdsd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_BIT  = 3'd1;
   localparam logic [2:0] S_FIN  = 3'd2;
   localparam logic [2:0] S_LOOK = 3'd3;
   localparam logic [2:0] S_CENT = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [3:0] phase_ff, phase_in;
   logic [6:0] rem_ff, rem_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] bitpos_ff, bitpos_in;
   logic       done_ff, done_in;
   logic       stepped;
   logic       can_emit;
   logic [6:0] rem_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_FLAG;
         rem_ff    <= 7'd1;
         bitpos_ff <= 3'd7;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         bitpos_ff <= bitpos_in;
         done_ff   <= done_in;
      end
      byte_ff <= byte_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign can_emit  = !status.pend_valid || status.out_free;
   assign rem_dec   = rem_ff - 7'd1;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      rem_in    = rem_ff;
      byte_in   = byte_ff;
      bitpos_in = bitpos_ff;
      done_in   = done_ff;
      cmd       = '0;
      stepped   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command) begin
                  cmd.restart = 1'b1;
                  cmd.clear   = 1'b1;
                  phase_in    = PH_FLAG;
                  rem_in      = 7'd1;
               end else begin
                  byte_in   = req_stream_byte;
                  bitpos_in = 3'd7;
                  done_in   = 1'b0;
                  state_in  = S_BIT;
               end
            end
         end
         S_BIT: begin
            cmd.shift     = 1'b1;
            cmd.shift_bit = byte_ff[bitpos_ff];
            rem_in        = rem_dec;
            done_in       = (bitpos_ff == 3'd0);
            bitpos_in     = bitpos_ff - 3'd1;
            if (rem_dec == 7'd0) begin
               state_in = S_FIN;
            end else if (bitpos_ff == 3'd0) begin
               state_in = S_END;
            end
         end
         S_FIN: begin
            stepped = 1'b1;
            cmd.clear = 1'b1;
            case (phase_ff)
               PH_FLAG: begin
                  phase_in = status.gather_low[0] ? PH_LCOUNT : PH_FTZ;
                  rem_in   = status.gather_low[0] ? 7'd5 : 7'd7;
               end
               PH_LCOUNT: begin
                  cmd.op = OP_LCOUNT; phase_in = PH_LENTRY; rem_in = 7'd6;
               end
               PH_TCOUNT: begin
                  cmd.op = OP_TCOUNT; phase_in = PH_TENTRY; rem_in = 7'd6;
               end
               PH_LENTRY: begin
                  cmd.op   = OP_LENTRY;
                  phase_in = status.fill_more ? PH_LENTRY : PH_TCOUNT;
                  rem_in   = status.fill_more ? 7'd6 : 7'd5;
               end
               PH_TENTRY: begin
                  cmd.op   = OP_TENTRY;
                  phase_in = status.fill_more ? PH_TENTRY : PH_FTZ;
                  rem_in   = status.fill_more ? 7'd6 : 7'd7;
               end
               PH_FTZ: begin
                  if (!status.gather_low[6]) begin
                     cmd.op   = OP_FTZ;
                     phase_in = PH_FBODY;
                     rem_in   = 7'(6'd63 - status.gather_low[5:0]);
                  end else if (can_emit) begin
                     cmd.op   = OP_EMIT_ZERO;
                     phase_in = PH_CTRL;
                     rem_in   = 7'd1;
                  end else begin
                     stepped = 1'b0; cmd.clear = 1'b0;
                  end
               end
               PH_FBODY: begin
                  if (can_emit) begin
                     cmd.op = OP_EMIT_BODY; phase_in = PH_CTRL; rem_in = 7'd1;
                  end else begin
                     stepped = 1'b0; cmd.clear = 1'b0;
                  end
               end
               PH_CTRL: begin
                  phase_in = status.gather_low[0] ? PH_CENTER : PH_CTRL2;
                  rem_in   = status.gather_low[0] ? status.center_width : 7'd1;
               end
               PH_CTRL2: begin
                  if (!status.gather_low[0]) begin
                     phase_in = PH_IDX;
                     rem_in   = {3'd0, status.index_width};
                  end else if (can_emit) begin
                     cmd.op = OP_EMIT_PREV; phase_in = PH_CTRL; rem_in = 7'd1;
                  end else begin
                     stepped = 1'b0; cmd.clear = 1'b0;
                  end
               end
               PH_IDX: begin
                  // table read is registered; hold the gather for the lookup
                  cmd.op    = OP_LOOKUP;
                  cmd.clear = 1'b0;
                  stepped   = 1'b0;
                  state_in  = S_LOOK;
               end
               PH_CENTER: begin
                  if (can_emit) begin
                     cmd.op = OP_EMIT_CENTER; phase_in = PH_CTRL; rem_in = 7'd1;
                  end else begin
                     stepped = 1'b0; cmd.clear = 1'b0;
                  end
               end
               default: begin
                  phase_in = status.awaiting ? PH_FLAG : PH_CTRL;
                  rem_in   = 7'd1;
               end
            endcase
         end
         S_LOOK: begin
            cmd.op   = OP_HELD;
            state_in = S_CENT;
         end
         S_CENT: begin
            stepped   = 1'b1;
            cmd.clear = 1'b1;
            phase_in  = PH_CENTER;
            rem_in    = status.center_width;
         end
         S_END: begin
            if (!status.pend_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.op   = OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // after a finish, keep finishing zero-width reads, else take next bit or end the byte
      if (stepped) begin
         if (rem_in == 7'd0) begin
            state_in = S_FIN;
         end else if (done_ff) begin
            state_in = S_END;
         end else begin
            state_in = S_BIT;
         end
      end
   end

endmodule

// ===== src/xdsd_dpath.sv =====
// ----------------------------------------------------------------------------
// xdsd_dpath
// Bit gather, zero-count tables, word rebuild and result register.
// ----------------------------------------------------------------------------
module xdsd_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  xdsd_pkg::cmd_type    cmd,
   output xdsd_pkg::status_type status,
   input  logic                 csr_wr_en,
   input  logic [63:0]          csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_value_bits,
   output logic                 rsp_end_of_stream,
   output logic                 rsp_last_of_run
);
   import xdsd_pkg::*;

   logic [5:0]  lead_mem [TABLE_DEPTH];
   logic [5:0]  trail_mem [TABLE_DEPTH];

   logic [63:0] end_marker_ff;
   logic [63:0] gather_ff;
   logic [63:0] prev_ff, prev_in;
   logic [5:0]  held_lead_ff, held_trail_ff;
   logic [2:0]  lead_bits_ff, trail_bits_ff;
   logic        awaiting_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  target_ff;
   logic [5:0]  first_shift_ff;
   logic [5:0]  lead_rd_ff, trail_rd_ff;
   logic        lead_oob_ff, trail_oob_ff;
   logic [63:0] pend_word_ff;
   logic        pend_valid_ff;
   logic [63:0] out_word_ff;
   logic        out_eos_ff, out_last_ff, out_valid_ff;

   logic        out_free;
   logic        emit;
   logic        push;
   logic [5:0]  count_target;
   logic [5:0]  fill_next;
   logic [4:0]  lead_idx, trail_idx;
   logic [6:0]  held_sum;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit      = (cmd.op == OP_EMIT_ZERO) || (cmd.op == OP_EMIT_BODY) ||
                      (cmd.op == OP_EMIT_PREV) || (cmd.op == OP_EMIT_CENTER);
   assign push      = pend_valid_ff && (emit || (cmd.op == OP_FLUSH));
   assign count_target = (gather_ff[4:0] == 5'd0) ? 6'd32 : {1'b0, gather_ff[4:0]};
   assign fill_next = fill_ff + 6'd1;
   assign lead_idx  = 5'(gather_ff[9:0] >> trail_bits_ff);
   assign trail_idx = gather_ff[4:0] & ~(5'h1f << trail_bits_ff);
   assign held_sum  = {1'b0, held_lead_ff} + {1'b0, held_trail_ff};

   always_comb begin
      case (cmd.op)
         OP_EMIT_ZERO:   prev_in = 64'd0;
         OP_EMIT_BODY:   prev_in = {gather_ff[62:0], 1'b1} << first_shift_ff;
         OP_EMIT_CENTER: prev_in = prev_ff ^ (gather_ff << held_trail_ff);
         default:        prev_in = prev_ff;
      endcase
   end

   always_comb begin
      status.pend_valid   = pend_valid_ff;
      status.out_free     = out_free;
      status.gather_low   = gather_ff[6:0];
      status.fill_more    = fill_next < target_ff;
      status.awaiting     = awaiting_ff;
      status.center_width = held_sum[6] ? 7'd0 : 7'(7'd64 - held_sum);
      status.index_width  = {1'b0, lead_bits_ff} + {1'b0, trail_bits_ff};
   end

   // tables: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LENTRY && fill_ff < 6'(TABLE_DEPTH)) begin
         lead_mem[fill_ff[TABLE_ADDR_W-1:0]] <= gather_ff[5:0];
      end
      if (cmd.op == OP_TENTRY && fill_ff < 6'(TABLE_DEPTH)) begin
         trail_mem[fill_ff[TABLE_ADDR_W-1:0]] <= gather_ff[5:0];
      end
      if (cmd.op == OP_LOOKUP) begin
         lead_rd_ff   <= lead_mem[lead_idx[TABLE_ADDR_W-1:0]];
         trail_rd_ff  <= trail_mem[trail_idx[TABLE_ADDR_W-1:0]];
         lead_oob_ff  <= {1'b0, lead_idx} >= 6'(TABLE_DEPTH);
         trail_oob_ff <= {1'b0, trail_idx} >= 6'(TABLE_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff  <= END_MARKER_RESET;
         gather_ff      <= '0;
         prev_ff        <= '0;
         held_lead_ff   <= '0;
         held_trail_ff  <= '0;
         lead_bits_ff   <= '0;
         trail_bits_ff  <= '0;
         awaiting_ff    <= 1'b1;
         fill_ff        <= '0;
         target_ff      <= '0;
         first_shift_ff <= '0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            end_marker_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            gather_ff <= '0;
         end else if (cmd.shift) begin
            gather_ff <= {gather_ff[62:0], cmd.shift_bit};
         end
         if (cmd.restart) begin
            awaiting_ff <= 1'b1;
         end
         case (cmd.op)
            OP_LCOUNT: begin
               target_ff    <= count_target;
               fill_ff      <= '0;
               lead_bits_ff <= index_width(count_target);
            end
            OP_TCOUNT: begin
               target_ff     <= count_target;
               fill_ff       <= '0;
               trail_bits_ff <= index_width(count_target);
            end
            OP_LENTRY, OP_TENTRY: begin
               fill_ff <= fill_next;
            end
            OP_FTZ: begin
               awaiting_ff    <= 1'b0;
               first_shift_ff <= gather_ff[5:0];
            end
            OP_EMIT_ZERO: begin
               awaiting_ff <= 1'b0;
            end
            OP_HELD: begin
               held_lead_ff  <= lead_oob_ff ? 6'd0 : lead_rd_ff;
               held_trail_ff <= trail_oob_ff ? 6'd0 : trail_rd_ff;
            end
            default: begin
            end
         endcase
         prev_ff <= prev_in;
         // newest word waits in the pending slot until the next one or the byte end
         if (emit) begin
            pend_word_ff  <= prev_in;
            pend_valid_ff <= 1'b1;
         end else if (cmd.op == OP_FLUSH) begin
            pend_valid_ff <= 1'b0;
         end
         if (push) begin
            out_word_ff  <= pend_word_ff;
            out_eos_ff   <= (pend_word_ff == end_marker_ff);
            out_last_ff  <= (cmd.op == OP_FLUSH);
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_value_bits    = out_word_ff;
   assign rsp_end_of_stream = out_eos_ff;
   assign rsp_last_of_run   = out_last_ff;

endmodule

// ===== tb/tb_xor_double_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_xor_double_stream_decoder_top
// Self-checking bench for the XOR double stream decoder: encodes streams of
// words, feeds them a byte per request and checks every decoded word in order.
// ----------------------------------------------------------------------------
module tb_xor_double_stream_decoder_top;
   import xdsd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic       command;
      logic [7:0] stream_byte;
   } byte_req_type;

   typedef struct {
      logic [63:0] value_bits;
      logic        end_of_stream;
      logic        last_of_run;
   } word_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value_bits;
   logic        rsp_end_of_stream;
   logic        rsp_last_of_run;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = 64'h0;

   xor_double_stream_decoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_bits    (rsp_value_bits),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Decoder prediction: bit-serial walk of the compressed stream
   // ------------------------------------------------------------------------
   logic [63:0] end_mark;
   logic [5:0]  lead_tab [TABLE_DEPTH];
   logic [5:0]  trail_tab [TABLE_DEPTH];
   int          lead_ix_w, trail_ix_w;
   logic [63:0] last_word;
   int          hold_lz, hold_tz;
   bit          want_first;
   logic [3:0]  phase;
   logic [63:0] gather;
   int          need_bits;
   int          fill_cnt, fill_target, first_sh;

   word_rsp_type decoded_words [$];
   word_rsp_type byte_words [$];

   function automatic int ix_bits(int n);
      int w;
      w = 0;
      while (w < 5 && (1 << w) < n) w++;
      return w;
   endfunction

   function automatic void go_phase(logic [3:0] ph, int n);
      phase     = ph;
      need_bits = n;
      gather    = 64'h0;
   endfunction

   function automatic void put_word(logic [63:0] w);
      word_rsp_type r;
      last_word = w;
      if (byte_words.size() < 8) begin
         r.value_bits    = w;
         r.end_of_stream = (w == end_mark);
         r.last_of_run   = 1'b0;
         byte_words.push_back(r);
      end
      go_phase(PH_CTRL, 1);
   endfunction

   function automatic void begin_center();
      int sum;
      sum = hold_lz + hold_tz;
      go_phase(PH_CENTER, (sum >= 64) ? 0 : 64 - sum);
   endfunction

   function automatic void close_field();
      logic [31:0] v;
      int li, ti;
      v = gather[31:0];
      case (phase)
         PH_FLAG: begin
            if (v[0]) go_phase(PH_LCOUNT, 5);
            else go_phase(PH_FTZ, 7);
         end
         PH_LCOUNT, PH_TCOUNT: begin
            fill_target = (v[4:0] != 0) ? int'(v[4:0]) : 32;
            fill_cnt    = 0;
            if (phase == PH_LCOUNT) begin
               lead_ix_w = ix_bits(fill_target);
               go_phase(PH_LENTRY, 6);
            end else begin
               trail_ix_w = ix_bits(fill_target);
               go_phase(PH_TENTRY, 6);
            end
         end
         PH_LENTRY, PH_TENTRY: begin
            if (fill_cnt < TABLE_DEPTH) begin
               if (phase == PH_LENTRY) lead_tab[fill_cnt] = v[5:0];
               else trail_tab[fill_cnt] = v[5:0];
            end
            fill_cnt = (fill_cnt + 1) & 63;
            if (fill_cnt < fill_target) go_phase(phase, 6);
            else if (phase == PH_LENTRY) go_phase(PH_TCOUNT, 5);
            else go_phase(PH_FTZ, 7);
         end
         PH_FTZ: begin
            want_first = 1'b0;
            if (v[6:0] < 64) begin
               first_sh = int'(v[5:0]);
               go_phase(PH_FBODY, 63 - first_sh);
            end else begin
               put_word(64'h0);
            end
         end
         PH_FBODY: put_word(((gather << 1) + 64'd1) << first_sh);
         PH_CTRL: begin
            if (v[0]) begin_center();
            else go_phase(PH_CTRL2, 1);
         end
         PH_CTRL2: begin
            if (v[0]) put_word(last_word);
            else go_phase(PH_IDX, lead_ix_w + trail_ix_w);
         end
         PH_IDX: begin
            li = int'((v >> trail_ix_w) & 32'd31);
            ti = int'(v & ((32'd1 << trail_ix_w) - 32'd1) & 32'd31);
            hold_lz = (li < TABLE_DEPTH) ? int'(lead_tab[li]) : 0;
            hold_tz = (ti < TABLE_DEPTH) ? int'(trail_tab[ti]) : 0;
            begin_center();
         end
         PH_CENTER: put_word(last_word ^ (gather << hold_tz));
         default: go_phase(want_first ? PH_FLAG : PH_CTRL, 1);
      endcase
   endfunction

   // Work out every word that one accepted request completes.
   function automatic void decode_request(logic cmd, logic [7:0] data);
      word_rsp_type r;
      byte_words.delete();
      if (cmd) begin
         want_first = 1'b1;
         go_phase(PH_FLAG, 1);
         return;
      end
      for (int b = 7; b >= 0; b--) begin
         gather = {gather[62:0], data[b]};
         if (need_bits > 0) need_bits--;
         while (need_bits == 0) close_field();
      end
      if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last_of_run = 1'b1;
      foreach (byte_words[i]) begin
         r = byte_words[i];
         decoded_words.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stream encoder: builds well-formed streams with random content
   // ------------------------------------------------------------------------
   byte_req_type pending_reqs [$];
   bit          code_bits [$];
   logic [5:0]  enc_lead [TABLE_DEPTH];
   logic [5:0]  enc_trail [TABLE_DEPTH];
   int          enc_lw = 0, enc_tw = 0, enc_lz = 0, enc_tz = 0;
   bit          enc_lost = 1'b0;   // encoder no longer knows the decoder context
   int          queued_reqs = 0;

   function automatic void push_bits(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) code_bits.push_back(v[i]);
   endfunction

   function automatic void push_req(logic cmd, logic [7:0] data);
      byte_req_type q;
      q.command     = cmd;
      q.stream_byte = data;
      pending_reqs.push_back(q);
      queued_reqs++;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic void load_tab(bit full, bit leading);
      int n;
      logic [5:0] e;
      n = (full || $urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 6);
      push_bits(n, 5);
      for (int i = 0; i < n; i++) begin
         e = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(32, 63)) : 6'($urandom);
         push_bits(e, 6);
         if (leading) enc_lead[i] = e;
         else enc_trail[i] = e;
      end
      if (leading) enc_lw = ix_bits(n);
      else enc_tw = ix_bits(n);
   endfunction

   function automatic void push_center();
      int w;
      w = (enc_lz + enc_tz >= 64) ? 0 : 64 - enc_lz - enc_tz;
      push_bits(rand_word(), w);
   endfunction

   // One restart followed by a first value and nvals later values.
   // Directed streams step through the three codes in turn.
   function automatic void queue_stream(int nvals, bit full, int first_kind, bit walk_codes);
      logic [63:0] w;
      int tz, code, li, ti, nbytes, keep;
      logic [7:0] data;
      bit force_lookup;
      code_bits.delete();
      push_req(1'b1, 8'($urandom));
      if (full || enc_lost || $urandom_range(0, 2) == 0) begin
         push_bits(1, 1);
         load_tab(full, 1'b1);
         load_tab(full, 1'b0);
      end else begin
         push_bits(0, 1);
      end
      case (first_kind)
         0: w = end_mark;
         1: w = 64'h0;
         2: w = '1;
         3: w = rand_word() << $urandom_range(0, 63);
         default: w = rand_word();
      endcase
      if (w == 64'h0) begin
         push_bits($urandom_range(64, 127), 7);
      end else begin
         tz = 0;
         while (!w[tz]) tz++;
         push_bits(tz, 7);
         push_bits(w >> (tz + 1), 63 - tz);
      end
      force_lookup = enc_lost;
      for (int i = 0; i < nvals; i++) begin
         code = walk_codes ? i % 3 : $urandom_range(0, 2);
         if (force_lookup) code = 1;
         force_lookup = 1'b0;
         case (code)
            0: begin
               push_bits(1, 1);
               push_center();
            end
            1: begin
               push_bits(0, 2);
               li = $urandom_range(0, (1 << enc_lw) - 1);
               ti = $urandom_range(0, (1 << enc_tw) - 1);
               push_bits(li, enc_lw);
               push_bits(ti, enc_tw);
               enc_lz = enc_lead[li];
               enc_tz = enc_trail[ti];
               push_center();
            end
            default: push_bits(1, 2);
         endcase
      end
      while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom));
      nbytes = code_bits.size() / 8;
      keep   = nbytes;
      enc_lost = 1'b0;
      // Cut the stream short now and then; the next stream reloads everything.
      if (!walk_codes && $urandom_range(0, 7) == 0) begin
         keep = $urandom_range(1, nbytes);
         enc_lost = 1'b1;
      end
      for (int k = 0; k < keep; k++) begin
         for (int b = 0; b < 8; b++) data[7 - b] = code_bits[k * 8 + b];
         push_req(1'b0, data);
      end
   endfunction

   // Raw random bytes; the decoder context is unknown afterwards.
   function automatic void queue_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) push_req(1'b0, 8'($urandom));
      enc_lost = 1'b1;
   endfunction

   function automatic void queue_random(int upto);
      while (queued_reqs < upto) begin
         if ($urandom_range(0, 9) == 0) queue_noise();
         else queue_stream($urandom_range(1, 10), 1'b0, $urandom_range(0, 4), 1'b0);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offer pending requests, predict on each accepted one
   // ------------------------------------------------------------------------
   bit quiet      = 1'b0;
   int send_gap   = 0;
   int sent_reqs  = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_request(req_command, req_stream_byte);
            sent_reqs++;
         end
         // hold the payload while stalled
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap  = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid       <= 1'b1;
               req_command     <= pending_reqs[0].command;
               req_stream_byte <= pending_reqs[0].stream_byte;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random stall bursts, one long hold-off, in-order compare
   // ------------------------------------------------------------------------
   bit hold_request = 1'b0;
   bit hold_taken   = 1'b0;
   int hold_left    = 0;
   int stall_gap    = 0;
   int errors       = 0;
   int checked      = 0;
   int marker_hits  = 0;

   always @(posedge clock) begin
      word_rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_words.size() == 0) begin
               $display("%0t: unexpected word exp=none act=%h", $time, rsp_value_bits);
               errors++;
            end else begin
               e = decoded_words.pop_front();
               checked++;
               if (e.end_of_stream) marker_hits++;
               if (rsp_value_bits !== e.value_bits) begin
                  $display("%0t: value_bits exp=%h act=%h", $time, e.value_bits,
                           rsp_value_bits);
                  errors++;
               end
               if (rsp_end_of_stream !== e.end_of_stream) begin
                  $display("%0t: end_of_stream exp=%b act=%b", $time, e.end_of_stream,
                           rsp_end_of_stream);
                  errors++;
               end
               if (rsp_last_of_run !== e.last_of_run) begin
                  $display("%0t: last_of_run exp=%b act=%b", $time, e.last_of_run,
                           rsp_last_of_run);
                  errors++;
               end
            end
         end
         // long hold-off lets the request side back up
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_gap = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Cycle limit
   // ------------------------------------------------------------------------
   int cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: directed streams, then random phases with marker changes
   // ------------------------------------------------------------------------
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || decoded_words.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_marker(logic [63:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      end_mark = v;
   endtask

   initial begin
      end_mark   = END_MARKER_RESET;
      last_word  = 64'h0;
      lead_ix_w  = 0;
      trail_ix_w = 0;
      hold_lz    = 0;
      hold_tz    = 0;
      want_first = 1'b1;
      fill_cnt   = 0;
      fill_target = 0;
      first_sh   = 0;
      go_phase(PH_FLAG, 1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: full tables first so every later lookup hits a written entry
      queue_stream(6, 1'b1, 0, 1'b1);
      queue_stream(3, 1'b0, 1, 1'b1);
      queue_stream(3, 1'b0, 2, 1'b1);
      drain();

      queue_random(125);
      drain();
      write_marker(64'h0);
      queue_random(150);
      drain();
      write_marker('1);
      hold_request <= 1'b1;
      queue_random(170);
      drain();
      write_marker(rand_word());
      quiet = 1'b1;
      queue_random(190);
      drain();
      write_marker(END_MARKER_RESET);
      queue_stream(4, 1'b0, 0, 1'b0);
      drain();

      $display("Covered %0d requests, %0d decoded words checked, %0d marker matches,",
               sent_reqs, checked, marker_hits);
      $display("four end-marker settings and one long receiver hold-off.");
      if (errors == 0 && decoded_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
